// ===== src/ows_pkg.sv =====
// shared types and codes for the one-wire search rom decision engine
// no dependencies; used by ows_engine and one_wire_rom_search
package ows_pkg;

   localparam int ROM_BITS  = 64;
   localparam int POS_WIDTH = $clog2(ROM_BITS);
   localparam int BP_WIDTH  = 7;
   localparam int ID_WIDTH  = 64;

   localparam logic [BP_WIDTH-1:0] NONE_POINT = '1;

   localparam logic [1:0] ACT_RESTART  = 2'd0;
   localparam logic [1:0] ACT_BEGIN    = 2'd1;
   localparam logic [1:0] ACT_BIT_PAIR = 2'd2;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_FOUND       = 3'd1;
   localparam logic [2:0] STATUS_EXHAUSTED   = 3'd2;
   localparam logic [2:0] STATUS_NO_PRESENCE = 3'd3;
   localparam logic [2:0] STATUS_NO_RESPONSE = 3'd4;
   localparam logic [2:0] STATUS_NOT_IN_PASS = 3'd5;

   typedef struct packed {
      logic [1:0] action;
      logic       presence;
      logic       bit_true;
      logic       bit_complement;
   } item_type;

   typedef struct packed {
      logic [2:0]          status;
      logic                direction;
      logic [ID_WIDTH-1:0] rom_id;
   } result_type;

endpackage

// ===== src/ows_engine.sv =====
// search state and per-item branch decision
// depends on ows_pkg; instantiated by one_wire_rom_search
module ows_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  ows_pkg::item_type  item,
   output ows_pkg::result_type result
);

   logic [ows_pkg::ROM_BITS-1:0]  rom_ff, rom_in;
   logic [ows_pkg::BP_WIDTH-1:0]  last_bp_ff, last_bp_in;
   logic [ows_pkg::BP_WIDTH-1:0]  pass_bp_ff, pass_bp_in;
   logic                          all_taken_ff, all_taken_in;
   logic                          exhausted_ff, exhausted_in;
   logic [ows_pkg::BP_WIDTH-1:0]  bit_pos_ff, bit_pos_in;
   logic                          pass_active_ff, pass_active_in;

   logic [ows_pkg::POS_WIDTH-1:0] pos;
   logic [ows_pkg::BP_WIDTH-1:0]  pos_ext;
   logic                          dir;

   assign pos     = bit_pos_ff[ows_pkg::POS_WIDTH-1:0];
   assign pos_ext = ows_pkg::BP_WIDTH'(pos);

   always_comb begin
      rom_in         = rom_ff;
      last_bp_in     = last_bp_ff;
      pass_bp_in     = pass_bp_ff;
      all_taken_in   = all_taken_ff;
      exhausted_in   = exhausted_ff;
      bit_pos_in     = bit_pos_ff;
      pass_active_in = pass_active_ff;
      dir            = item.bit_true;
      result         = '0;
      result.status  = ows_pkg::STATUS_NOT_IN_PASS;
      unique case (item.action)
         ows_pkg::ACT_RESTART: begin
            rom_in         = '0;
            last_bp_in     = ows_pkg::NONE_POINT;
            pass_bp_in     = ows_pkg::NONE_POINT;
            all_taken_in   = 1'b1;
            exhausted_in   = 1'b0;
            bit_pos_in     = '0;
            pass_active_in = 1'b0;
            result.status  = ows_pkg::STATUS_OK;
         end
         ows_pkg::ACT_BEGIN: begin
            pass_active_in = 1'b0;
            if (exhausted_ff) begin
               result.status = ows_pkg::STATUS_EXHAUSTED;
            end else if (!item.presence) begin
               result.status = ows_pkg::STATUS_NO_PRESENCE;
            end else begin
               pass_active_in = 1'b1;
               bit_pos_in     = '0;
               pass_bp_in     = ows_pkg::NONE_POINT;
               all_taken_in   = 1'b1;
               result.status  = ows_pkg::STATUS_OK;
            end
         end
         ows_pkg::ACT_BIT_PAIR: begin
            if (!pass_active_ff) begin
               result.status = ows_pkg::STATUS_NOT_IN_PASS;
            end else if (item.bit_true && item.bit_complement) begin
               pass_active_in = 1'b0;
               result.status  = ows_pkg::STATUS_NO_RESPONSE;
            end else begin
               if (!item.bit_true && !item.bit_complement) begin
                  if (last_bp_ff != ows_pkg::NONE_POINT && pos_ext == last_bp_ff) begin
                     // pending junction: take the one side now
                     dir        = 1'b1;
                     last_bp_in = pass_bp_ff;
                  end else if (last_bp_ff != ows_pkg::NONE_POINT && pos_ext < last_bp_ff) begin
                     dir = rom_ff[pos];
                     if (!dir) begin
                        all_taken_in = 1'b0;
                        pass_bp_in   = pos_ext;
                     end
                  end else begin
                     // new ground: take zero
                     dir          = 1'b0;
                     last_bp_in   = pos_ext;
                     pass_bp_in   = pos_ext;
                     all_taken_in = 1'b0;
                  end
               end
               rom_in[pos]      = dir;
               bit_pos_in       = bit_pos_ff + 1'b1;
               result.direction = dir;
               result.status    = ows_pkg::STATUS_OK;
               if (bit_pos_in >= ows_pkg::BP_WIDTH'(ows_pkg::ROM_BITS)) begin
                  pass_active_in = 1'b0;
                  bit_pos_in     = '0;
                  exhausted_in   = exhausted_ff | all_taken_in;
                  result.status  = ows_pkg::STATUS_FOUND;
                  result.rom_id  = ows_pkg::ID_WIDTH'(rom_in);
               end
            end
         end
         default: begin
            result.status = ows_pkg::STATUS_NOT_IN_PASS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff         <= '0;
         last_bp_ff     <= ows_pkg::NONE_POINT;
         pass_bp_ff     <= ows_pkg::NONE_POINT;
         all_taken_ff   <= 1'b1;
         exhausted_ff   <= 1'b0;
         bit_pos_ff     <= '0;
         pass_active_ff <= 1'b0;
      end else if (fire) begin
         rom_ff         <= rom_in;
         last_bp_ff     <= last_bp_in;
         pass_bp_ff     <= pass_bp_in;
         all_taken_ff   <= all_taken_in;
         exhausted_ff   <= exhausted_in;
         bit_pos_ff     <= bit_pos_in;
         pass_active_ff <= pass_active_in;
      end
   end

   // position stays inside the rom while a pass runs
   assert property (@(posedge clock) disable iff (reset)
      pass_active_ff |-> bit_pos_ff < ows_pkg::BP_WIDTH'(ows_pkg::ROM_BITS))
      else $error("bit position beyond rom during pass");

   // a pass never runs once the enumeration is exhausted
   assert property (@(posedge clock) disable iff (reset)
      fire && item.action == ows_pkg::ACT_BEGIN && exhausted_ff |=> !pass_active_ff)
      else $error("pass started while exhausted");

   // a found rom always ends the pass and rewinds the position
   assert property (@(posedge clock) disable iff (reset)
      fire && result.status == ows_pkg::STATUS_FOUND |=> !pass_active_ff && bit_pos_ff == '0)
      else $error("pass not closed after found rom");

endmodule

// ===== src/one_wire_rom_search.sv =====
// Search-ROM decision engine for a one-wire bus master. Each accepted item
// (restart, pass start with presence, or a true/complement bit pair) gives
// exactly one result, moved from the input register into the result register; a
// new item can be accepted every clock cycle, limited only by rsp_stall. The
// per-item decision is a single pass of logic between the input register
// and the result register, and the search state updates as the item moves
// into the result register. No clearing pass follows reset.
// top level: input register, result register; depends on ows_pkg, ows_engine
module one_wire_rom_search (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic                         req_presence,
   input  logic                         req_bit_true,
   input  logic                         req_bit_complement,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic                         rsp_direction,
   output logic [ows_pkg::ID_WIDTH-1:0] rsp_rom_id
);

   logic                in_valid_ff, in_valid_in;
   ows_pkg::item_type   in_item_ff;
   logic                out_valid_ff, out_valid_in;
   ows_pkg::result_type out_ff;
   ows_pkg::result_type result;
   logic                advance;
   logic                fire;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff.action         <= req_action;
         in_item_ff.presence       <= req_presence;
         in_item_ff.bit_true       <= req_bit_true;
         in_item_ff.bit_complement <= req_bit_complement;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   ows_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_ff.status;
   assign rsp_direction = out_ff.direction;
   assign rsp_rom_id    = out_ff.rom_id;

   // a held item is not dropped while the result side is stalled
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |=> in_valid_ff)
      else $error("pending item lost under stall");

   // rom id only carries data with a found device
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ows_pkg::STATUS_FOUND |-> rsp_rom_id == '0)
      else $error("rom id set without found status");

   // error answers carry no write-back bit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ows_pkg::STATUS_EXHAUSTED ||
                    rsp_status == ows_pkg::STATUS_NO_PRESENCE ||
                    rsp_status == ows_pkg::STATUS_NO_RESPONSE ||
                    rsp_status == ows_pkg::STATUS_NOT_IN_PASS) |-> !rsp_direction)
      else $error("direction set on error status");

endmodule
